// ----- rtl/distinct_value_counter_defines.svh -----
// Assertion macros shared by the distinct value counter RTL.
`ifndef DISTINCT_VALUE_COUNTER_DEFINES_SVH
`define DISTINCT_VALUE_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define DVC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dvc assertion failed");
// Next-cycle implication, disabled during reset.
`define DVC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dvc assertion failed");
`else
`define DVC_ASSERT_IMP(label, clk, rst, ante, cons)
`define DVC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- rtl/dvc_pkg.sv -----
// Types, constants and codes of the distinct value counter.
package dvc_pkg;

  localparam int MAX_CATEGORIES = 64;
  localparam int VALUE_BITS     = 64;
  localparam int COUNT_BITS     = 32;

  localparam int IDX_W   = $clog2(MAX_CATEGORIES);
  localparam int TOTAL_W = $clog2(MAX_CATEGORIES + 1);

  // Port widths of the channels
  localparam int REQ_W       = 2;
  localparam int IN_VALUE_W  = 64;
  localparam int IN_INDEX_W  = 6;
  localparam int OUT_INDEX_W = 6;
  localparam int OUT_COUNT_W = 32;
  localparam int OUT_VALUE_W = 64;
  localparam int OUT_TOTAL_W = 7;

  // Configuration port
  localparam int PADDR_W = 2;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_IS_ALPHA = '0;

  typedef enum logic [REQ_W-1:0] {
    REQ_UPDATE = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_READ   = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_RDWAIT,
    S_PUSH
  } state_t;

  typedef enum logic [2:0] {
    FIN_HOLD,
    FIN_EMPTY,
    FIN_HIT,
    FIN_MISS,
    FIN_READ
  } finish_t;

  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_issue;
    logic    read_issue;
    finish_t finish;
    logic    push;
  } dvc_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             scan_more;
    logic             rd_live;
    logic             match;
    logic             index_ok;
  } dvc_sts_t;

  typedef struct packed {
    logic                  found;
    logic [IDX_W-1:0]      index;
    logic [COUNT_BITS-1:0] count;
    logic [VALUE_BITS-1:0] value;
    logic                  origin;
    logic [TOTAL_W-1:0]    total;
    logic                  overflow;
  } dvc_res_t;

endpackage

// ----- rtl/dvc_ifs.sv -----
// Request and response channel interfaces of the distinct value counter.
interface dvc_req_if;
  import dvc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [REQ_W-1:0]      req_type;
  logic [IN_VALUE_W-1:0] value_in;
  logic [IN_INDEX_W-1:0] index_in;

  modport source (output valid, req_type, value_in, index_in, input ready);
  modport sink (input valid, req_type, value_in, index_in, output ready);
endinterface

interface dvc_rsp_if;
  import dvc_pkg::*;
  logic                   valid;
  logic                   ready;
  logic                   found;
  logic [OUT_INDEX_W-1:0] index_out;
  logic [OUT_COUNT_W-1:0] count_out;
  logic [OUT_VALUE_W-1:0] value_out;
  logic                   is_origin;
  logic [OUT_TOTAL_W-1:0] entry_total;
  logic                   overflow;

  modport source (output valid, found, index_out, count_out, value_out, is_origin,
                  entry_total, overflow, input ready);
  modport sink (input valid, found, index_out, count_out, value_out, is_origin,
                entry_total, overflow, output ready);
endinterface

// ----- rtl/dvc_datapath.sv -----
// Datapath: table memories, scan counter, entry count and result registers.
`include "distinct_value_counter_defines.svh"

module dvc_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          is_alpha,
  input  logic [dvc_pkg::REQ_W-1:0]     req_type,
  input  logic [dvc_pkg::IN_VALUE_W-1:0] value_in,
  input  logic [dvc_pkg::IN_INDEX_W-1:0] index_in,
  input  dvc_pkg::dvc_cmd_t             cmd,
  output dvc_pkg::dvc_sts_t             sts,
  output dvc_pkg::dvc_res_t             res_out
);
  import dvc_pkg::*;

  logic [VALUE_BITS-1:0] value_mem [MAX_CATEGORIES];
  logic [COUNT_BITS-1:0] count_mem [MAX_CATEGORIES];

  logic [REQ_W-1:0]      req_q;
  logic [VALUE_BITS-1:0] key;
  logic [IDX_W-1:0]      idx_q;

  logic [TOTAL_W-1:0]    scan_idx;
  logic [TOTAL_W-1:0]    entry_count;
  logic [TOTAL_W-1:0]    entry_count_next;

  logic [VALUE_BITS-1:0] value_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [IDX_W-1:0]      rd_idx;
  logic                  rd_live;

  logic                  rd_en;
  logic                  issue_scan;
  logic [IDX_W-1:0]      rd_addr;

  logic                  wr_value;
  logic                  wr_count;
  logic [IDX_W-1:0]      wr_addr;
  logic [COUNT_BITS-1:0] wr_data;

  logic                  upd_active;
  logic                  has_room;
  logic [COUNT_BITS-1:0] count_inc;

  dvc_res_t res;
  dvc_res_t res_next;

  assign issue_scan = cmd.scan_issue && (scan_idx < entry_count);
  assign rd_en      = issue_scan || cmd.read_issue;
  assign rd_addr    = cmd.read_issue ? idx_q : scan_idx[IDX_W-1:0];

  assign upd_active = (req_q == REQ_UPDATE) && is_alpha;
  assign has_room   = entry_count < TOTAL_W'(MAX_CATEGORIES);
  assign count_inc  = (count_q == '1) ? count_q : count_q + 1'b1;

  assign sts.req       = req_q;
  assign sts.scan_more = scan_idx < entry_count;
  assign sts.rd_live   = rd_live;
  assign sts.match     = rd_live && (value_q == key);
  assign sts.index_ok  = TOTAL_W'(idx_q) < entry_count;

  // Request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req_type;
      key   <= VALUE_BITS'(value_in);
      idx_q <= IDX_W'(index_in);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx    <= '0;
      entry_count <= '0;
      rd_live     <= 1'b0;
    end else begin
      if (cmd.scan_start) begin
        scan_idx <= '0;
      end else if (issue_scan) begin
        scan_idx <= scan_idx + 1'b1;
      end
      entry_count <= entry_count_next;
      rd_live     <= rd_en;
    end
  end

  // Memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_value) begin
      value_mem[wr_addr] <= key;
    end
    if (rd_en) begin
      value_q <= value_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_count) begin
      count_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      count_q <= count_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
  end

  always_comb begin
    res_next         = res;
    entry_count_next = entry_count;
    wr_value         = 1'b0;
    wr_count         = 1'b0;
    wr_addr          = rd_idx;
    wr_data          = count_inc;
    case (cmd.finish)
      FIN_EMPTY: begin
        res_next       = '0;
        res_next.total = entry_count;
      end
      FIN_HIT: begin
        res_next.found    = 1'b1;
        res_next.index    = rd_idx;
        res_next.count    = upd_active ? count_inc : count_q;
        res_next.value    = value_q;
        res_next.origin   = (rd_idx == '0) && is_alpha;
        res_next.total    = entry_count;
        res_next.overflow = 1'b0;
        wr_count          = upd_active;
      end
      FIN_MISS: begin
        res_next       = '0;
        res_next.total = entry_count;
        if (upd_active) begin
          if (has_room) begin
            // Append with a count of one
            wr_addr          = entry_count[IDX_W-1:0];
            wr_data          = COUNT_BITS'(1);
            wr_value         = 1'b1;
            wr_count         = 1'b1;
            entry_count_next = entry_count + 1'b1;
            res_next.index   = entry_count[IDX_W-1:0];
            res_next.count   = COUNT_BITS'(1);
            res_next.value   = key;
            res_next.origin  = (entry_count == '0);
            res_next.total   = entry_count + 1'b1;
          end else begin
            res_next.overflow = 1'b1;
          end
        end
      end
      FIN_READ: begin
        res_next.found    = 1'b1;
        res_next.index    = rd_idx;
        res_next.count    = count_q;
        res_next.value    = value_q;
        res_next.origin   = (rd_idx == '0) && is_alpha;
        res_next.total    = entry_count;
        res_next.overflow = 1'b0;
      end
      default: begin
        res_next = res;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (cmd.push) begin
      res_out <= res;
    end
  end

  `DVC_ASSERT_NEXT(a_count_only_on_miss, clk, rst, cmd.finish != FIN_MISS, $stable(entry_count))
  `DVC_ASSERT_IMP(a_match_in_range, clk, rst, sts.match, TOTAL_W'(rd_idx) < entry_count)
  `DVC_ASSERT_IMP(a_no_double_read, clk, rst, cmd.read_issue, !issue_scan)

endmodule

// ----- rtl/dvc_ctrl.sv -----
// Controller: sequences accept, scan, read, finish and output hand-off.
`include "distinct_value_counter_defines.svh"

module dvc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  dvc_pkg::dvc_sts_t sts,
  output dvc_pkg::dvc_cmd_t cmd
);
  import dvc_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_START;
      end
      S_START: begin
        if ((sts.req == REQ_UPDATE) || (sts.req == REQ_FIND)) begin
          state_next = S_SCAN;
        end else if ((sts.req == REQ_READ) && sts.index_ok) begin
          state_next = S_RDWAIT;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_SCAN: begin
        if (sts.match || (!sts.scan_more && !sts.rd_live)) state_next = S_PUSH;
      end
      S_RDWAIT: begin
        state_next = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.finish     = FIN_HOLD;
    in_ready       = 1'b0;
    out_valid_next = out_ready ? 1'b0 : out_valid;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START: begin
        if ((sts.req == REQ_UPDATE) || (sts.req == REQ_FIND)) begin
          cmd.scan_start = 1'b1;
        end else if ((sts.req == REQ_READ) && sts.index_ok) begin
          cmd.read_issue = 1'b1;
        end else begin
          cmd.finish = FIN_EMPTY;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.match) begin
          cmd.finish = FIN_HIT;
        end else if (!sts.scan_more && !sts.rd_live) begin
          cmd.finish = FIN_MISS;
        end
      end
      S_RDWAIT: begin
        cmd.finish = FIN_READ;
      end
      S_PUSH: begin
        if (out_free) begin
          cmd.push       = 1'b1;
          out_valid_next = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `DVC_ASSERT_NEXT(a_accept_starts, clk, rst, in_valid && in_ready, state == S_START)
  `DVC_ASSERT_NEXT(a_push_shows, clk, rst, cmd.push, out_valid && (state == S_IDLE))
  `DVC_ASSERT_IMP(a_push_when_free, clk, rst, cmd.push, !out_valid || out_ready)

endmodule

// ----- rtl/distinct_value_counter.sv -----
// Top level of the distinct value counter: channels, config register, control and datapath.
//
// Usage:
// - req (sink): one transfer per request. req_type selects update (count value_in,
//   appending it in first-seen order if new), find (look up value_in) or read (report
//   the entry at index_in). Code 3 returns an empty result.
// - rsp (source): exactly one result per request, in request order.
// - APB port: a single register, is_alpha at address 0 (reset 1). Write it only while
//   the block is idle; with is_alpha low an update acts as a find and is_origin is 0.
// A hit on entry k (from 0) ends the scan at entry k, a miss scans every stored entry, a
// read makes one read of the table and an empty result none. The linear scan, one
// registered read of the value memory per cycle, sets the time taken; the worst case is
// a miss over a full table of 64 entries.
// One request is worked on at a time: the next transfer is taken in the cycle after the
// result enters the output register.
// Reset empties the table at once (the entry count goes to zero); no clearing pass.
// A stalled receiver is decoupled by the output register: the next request is taken
// and worked on while a result waits, and only its own hand-off waits for the slot.
module distinct_value_counter (
  input  logic                       clk,
  input  logic                       rst,
  dvc_req_if.sink                    req,
  dvc_rsp_if.source                  rsp,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dvc_pkg::PADDR_W-1:0] paddr,
  input  logic [dvc_pkg::PDATA_W-1:0] pwdata,
  output logic [dvc_pkg::PDATA_W-1:0] prdata,
  output logic                       pready
);
  import dvc_pkg::*;

  logic     is_alpha;
  dvc_cmd_t cmd;
  dvc_sts_t sts;
  dvc_res_t res;

  // Configuration: zero wait states; every write lands in is_alpha
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_IS_ALPHA) ? PDATA_W'(is_alpha) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_alpha <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      is_alpha <= pwdata[0];
    end
  end

  // Sequencer: owns the handshakes and steps the datapath
  dvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table memories, scan and result registers
  dvc_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .is_alpha (is_alpha),
    .req_type (req.req_type),
    .value_in (req.value_in),
    .index_in (req.index_in),
    .cmd      (cmd),
    .sts      (sts),
    .res_out  (res)
  );

  // Drive the response payload from the output register, sized to the port widths
  assign rsp.found       = res.found;
  assign rsp.index_out   = OUT_INDEX_W'(res.index);
  assign rsp.count_out   = OUT_COUNT_W'(res.count);
  assign rsp.value_out   = OUT_VALUE_W'(res.value);
  assign rsp.is_origin   = res.origin;
  assign rsp.entry_total = OUT_TOTAL_W'(res.total);
  assign rsp.overflow    = res.overflow;

endmodule

// ----- tb/tb_distinct_value_counter.sv -----
// Self-checking testbench for the distinct value counter: register, directed, random and full-table runs.
module tb_distinct_value_counter;
  timeunit 1ns;
  timeprecision 1ps;

  import dvc_pkg::*;

  // req_type 3 has no member in req_t; the block answers it with an empty result.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 1000;
  localparam int RANDOM_PHASES = 5;
  localparam int POOL_SIZE = 40;
  localparam int MAX_WAIT = 13;
  // Wait longer than the worst hit or miss on a full table takes, to catch strays.
  localparam int SETTLE_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  dvc_req_if req_ch ();
  dvc_rsp_if rsp_ch ();

  distinct_value_counter dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Predicted table contents, held at the block's widths.
  logic [VALUE_BITS-1:0] seen_value [MAX_CATEGORIES];
  logic [COUNT_BITS-1:0] seen_count [MAX_CATEGORIES];
  int                    n_entries = 0;
  logic                  alpha_mode = 1'b1;

  // Results predicted at each request transfer, oldest first.
  dvc_res_t pending_tallies [$];

  int  fail_count = 0;
  // Clear to run a stretch with back-to-back transfers on both channels.
  bit  idling_on = 1'b1;

  logic [VALUE_BITS-1:0] value_pool [POOL_SIZE];

  // Work out the result of one request and advance the predicted table.
  function automatic dvc_res_t tally_step(logic [REQ_W-1:0] kind, logic [VALUE_BITS-1:0] v,
                                          logic [IN_INDEX_W-1:0] idx);
    dvc_res_t r;
    bit       fnd;
    bit       hit;
    int       at;
    r   = '0;
    fnd = 1'b0;
    hit = 1'b0;
    at  = 0;
    if (kind == REQ_UPDATE || kind == REQ_FIND) begin
      for (int i = 0; i < n_entries; i++) begin
        if (!fnd && seen_value[i] == v) begin
          fnd = 1'b1;
          at  = i;
        end
      end
      hit = fnd;
      // An update acts as a plain find unless the variable is categorical.
      if (kind == REQ_UPDATE && alpha_mode) begin
        if (fnd) begin
          // Saturate the count at its largest value.
          if (seen_count[at] != '1) seen_count[at] = seen_count[at] + 1'b1;
        end else if (n_entries < MAX_CATEGORIES) begin
          at             = n_entries;
          seen_value[at] = v;
          seen_count[at] = COUNT_BITS'(1);
          n_entries++;
          hit = 1'b1;
        end else begin
          r.overflow = 1'b1;
        end
      end
    end else if (kind == REQ_READ) begin
      if (idx < n_entries) begin
        at  = int'(idx);
        fnd = 1'b1;
        hit = 1'b1;
      end
    end
    r.found = fnd;
    if (hit) begin
      r.index  = IDX_W'(at);
      r.count  = seen_count[at];
      r.value  = seen_value[at];
      r.origin = (at == 0) && alpha_mode;
    end
    r.total = TOTAL_W'(n_entries);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // Compare every result transfer with the oldest prediction.
  always @(posedge clk) begin : check_results
    dvc_res_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_tallies.size() == 0) begin
        $error("result transfer with no request outstanding");
        fail_count++;
      end else begin
        want = pending_tallies.pop_front();
        check_field("found", want.found, rsp_ch.found);
        check_field("index_out", want.index, rsp_ch.index_out);
        check_field("count_out", want.count, rsp_ch.count_out);
        check_field("value_out", want.value, rsp_ch.value_out);
        check_field("is_origin", want.origin, rsp_ch.is_origin);
        check_field("entry_total", want.total, rsp_ch.entry_total);
        check_field("overflow", want.overflow, rsp_ch.overflow);
      end
    end
  end

  // Receiver: stall for a random number of cycles before each result transfer.
  // Keep ready high across transfers when no stall is drawn, so it never
  // drops and rises within one edge.
  initial begin : drive_ready
    int gap;
    rsp_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      gap = idling_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_ch.valid && rsp_ch.ready));
    end
  end

  // Present one request after a random gap, hold it until the transfer,
  // then record its predicted result. Leave valid high on return so a
  // following request with no gap goes out back to back.
  task automatic send_item(logic [REQ_W-1:0] kind, logic [VALUE_BITS-1:0] v,
                           logic [IN_INDEX_W-1:0] idx);
    int gap;
    gap = idling_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.req_type <= kind;
    req_ch.value_in <= v;
    req_ch.index_in <= idx;
    do @(posedge clk); while (!req_ch.ready);
    pending_tallies.push_back(tally_step(kind, v, idx));
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_tallies.size() != 0);
  endtask

  // APB read: setup phase, then access phase until pready, then back to idle.
  task automatic reg_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Change is_alpha with the block idle, then read it back.
  task automatic set_category_mode(logic mode);
    logic [PDATA_W-1:0] rd;
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_IS_ALPHA;
    pwdata  <= PDATA_W'(mode);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    alpha_mode = mode;
    @(posedge clk);
    reg_read(ADDR_IS_ALPHA, rd);
    check_field("is_alpha", mode, rd[0]);
  endtask

  task automatic test_register_access();
    logic [PDATA_W-1:0] rd;
    // Check the reset value, then toggle the register both ways.
    reg_read(ADDR_IS_ALPHA, rd);
    check_field("is_alpha", 1'b1, rd[0]);
    set_category_mode(1'b0);
    set_category_mode(1'b1);
  endtask

  task automatic test_directed_cases();
    idling_on = 1'b1;
    // Empty table: nothing to read or find.
    send_item(REQ_READ, '0, 6'd0);
    send_item(REQ_FIND, '0, 6'd0);
    // Fill a few entries at the value extremes; the second zero is a hit on the origin.
    send_item(REQ_UPDATE, '0, 6'd0);
    send_item(REQ_UPDATE, '1, 6'd63);
    send_item(REQ_UPDATE, '0, 6'd0);
    send_item(REQ_UPDATE, 64'h8000_0000_0000_0000, 6'd0);
    send_item(REQ_UPDATE, 64'h0000_0000_0000_0001, 6'd0);
    // Hit, then a miss one bit away from a stored value.
    send_item(REQ_FIND, '1, 6'd0);
    send_item(REQ_FIND, 64'hFFFF_FFFF_FFFF_FFFE, 6'd0);
    // Reads inside, at and past the stored count.
    send_item(REQ_READ, '1, 6'd1);
    send_item(REQ_READ, '0, 6'd3);
    send_item(REQ_READ, '0, 6'd4);
    send_item(REQ_READ, '1, 6'd63);
    // Unused code, with payload bits both ways.
    send_item(REQ_UNUSED, '1, 6'd63);
    send_item(REQ_UNUSED, '0, 6'd0);
    // Numeric variable: updates act as finds and origin stays low.
    set_category_mode(1'b0);
    send_item(REQ_UPDATE, 64'h0000_0000_0000_1234, 6'd0);
    send_item(REQ_UPDATE, '0, 6'd0);
    send_item(REQ_FIND, '0, 6'd0);
    send_item(REQ_READ, '0, 6'd0);
    set_category_mode(1'b1);
    send_item(REQ_UPDATE, '1, 6'd0);
    send_item(REQ_READ, '0, 6'd0);
    wait_idle();
  endtask

  task automatic test_random_traffic();
    int pick;
    logic [REQ_W-1:0]      kind;
    logic [VALUE_BITS-1:0] v;
    logic [IN_INDEX_W-1:0] idx;
    // Keep a small pool of values so most updates and finds hit; half the
    // pool sits one bit away from the other half to test the full compare.
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i < POOL_SIZE / 2) value_pool[i] = {$urandom, $urandom};
      else value_pool[i] = value_pool[i - POOL_SIZE / 2] ^ (64'd1 << $urandom_range(0, 63));
    end
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Vary the variable type (numeric in the second and last phase); run one phase with no idling at all.
      set_category_mode((p % 3) != 1);
      idling_on = (p != 2);
      for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 50) kind = REQ_UPDATE;
        else if (pick < 75) kind = REQ_FIND;
        else if (pick < 92) kind = REQ_READ;
        else kind = REQ_UNUSED;
        // Rarely bring in a fresh value on updates, more often on finds.
        pick = $urandom_range(0, 99);
        if ((kind == REQ_UPDATE && pick < 4) || (kind != REQ_UPDATE && pick < 20))
          v = {$urandom, $urandom};
        else
          v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (kind == REQ_READ && $urandom_range(0, 9) < 7)
          idx = IN_INDEX_W'($urandom_range(0, n_entries > 0 ? n_entries - 1 : 0));
        else
          idx = IN_INDEX_W'($urandom_range(0, 63));
        send_item(kind, v, idx);
      end
    end
    wait_idle();
  endtask

  task automatic test_full_table();
    int pick;
    idling_on = 1'b1;
    set_category_mode(1'b1);
    // Fill every free slot; a repeated random value just counts up.
    while (n_entries < MAX_CATEGORIES)
      send_item(REQ_UPDATE, {$urandom, $urandom}, IN_INDEX_W'($urandom_range(0, 63)));
    // Full table: overflow, hits deep in the table, full-length misses.
    for (int mode = 1; mode >= 0; mode--) begin
      set_category_mode(mode[0]);
      for (int n = 0; n < 30; n++) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0: send_item(REQ_UPDATE, {$urandom, $urandom}, 6'd0);
          1: send_item(REQ_UPDATE, seen_value[$urandom_range(0, MAX_CATEGORIES - 1)], 6'd0);
          2: send_item(REQ_FIND, {$urandom, $urandom}, 6'd63);
          3: send_item(REQ_FIND, seen_value[MAX_CATEGORIES - 1], 6'd0);
          4: send_item(REQ_READ, {$urandom, $urandom}, IN_INDEX_W'($urandom_range(0, 63)));
          default: send_item(REQ_UNUSED, {$urandom, $urandom},
                             IN_INDEX_W'($urandom_range(0, 63)));
        endcase
      end
    end
    wait_idle();
  endtask

  initial begin
    // Drive every block input to a known value before the first edge.
    req_ch.valid    <= 1'b0;
    req_ch.req_type <= REQ_UPDATE;
    req_ch.value_in <= '0;
    req_ch.index_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_access();
    test_directed_cases();
    test_random_traffic();
    test_full_table();

    // Give any stray result time to show up before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Stop a hung run; several times the slowest correct run.
  initial begin
    #4ms;
    $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/dvc_pkg.sv
rtl/dvc_ifs.sv
rtl/dvc_datapath.sv
rtl/dvc_ctrl.sv
rtl/distinct_value_counter.sv
tb/tb_distinct_value_counter.sv
